FILE: rtl/smpq_pkg.sv
// Package of shared constants and types for the sorted max-priority queue.
package smpq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

FILE: rtl/smpq_cell.sv
// One storage cell of the sorted chain: keeps, takes the new value or shifts.
module smpq_cell (
    input  logic                aclk,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  smpq_pkg::val_t      ins_value,
    input  logic                occupied,
    input  logic                left_ge,
    input  smpq_pkg::val_t      left_value,
    input  smpq_pkg::val_t      right_value,
    output smpq_pkg::val_t      cell_value,
    output logic                ge
);

    smpq_pkg::val_t value_reg;
    smpq_pkg::val_t value_next;

    assign ge = occupied && (value_reg >= ins_value);
    assign cell_value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.ins_en) begin
            if (ge) begin
                value_next = value_reg;
            end else if (left_ge) begin
                value_next = ins_value;
            end else begin
                value_next = left_value;
            end
        end else if (ctrl.rem_en) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/sorted_max_priority_queue_top.sv
// Top level of the sorted max-priority queue built as a chain of cells.
//
//  channel  | ports                                              | direction
//  ---------+----------------------------------------------------+----------
//  input    | s_valid s_ready s_op s_item_value                  | in
//  result   | m_valid m_ready m_head_value m_was_empty           | out
//           | m_overflow m_occupancy                             |
//
// All cells compare against the new value at once and shift in the same edge,
// so one item is accepted per cycle while the result register can take it.
// The result register holds one result; a new item is taken while it is empty
// or being taken in the same cycle. Reset clears the count and the result
// valid flag; cell contents are left as they are.
module sorted_max_priority_queue_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic signed [31:0]    s_item_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_head_value,
    output logic                  m_was_empty,
    output logic                  m_overflow,
    output logic [4:0]            m_occupancy
);

    localparam int DEPTH = smpq_pkg::DEPTH;

    smpq_pkg::cnt_t count_reg;
    smpq_pkg::cnt_t count_next;
    logic           m_valid_reg;
    smpq_pkg::val_t m_head_value_reg;
    logic           m_was_empty_reg;
    logic           m_overflow_reg;
    smpq_pkg::occ_t m_occupancy_reg;

    smpq_pkg::val_t head_next;
    logic           was_empty_next;
    logic           overflow_next;

    logic                 accept;
    logic                 is_empty;
    logic                 is_full;
    smpq_pkg::cell_ctrl_t ctrl;

    smpq_pkg::val_t cell_values [DEPTH];
    logic [DEPTH-1:0] cell_ge;
    logic [DEPTH-1:0] cell_occ;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == smpq_pkg::cnt_t'(DEPTH));

    assign ctrl.ins_en = accept && (s_op == smpq_pkg::OP_INSERT) && !is_full;
    assign ctrl.rem_en = accept && (s_op == smpq_pkg::OP_REMOVE) && !is_empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = smpq_pkg::cnt_t'(i) < count_reg;
        smpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .ins_value   (s_item_value),
            .occupied    (cell_occ[i]),
            .left_ge     ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
            .left_value  (cell_values[(i == 0) ? 0 : i - 1]),
            .right_value (cell_values[(i == DEPTH - 1) ? i : i + 1]),
            .cell_value  (cell_values[i]),
            .ge          (cell_ge[i])
        );
    end

    always_comb begin
        count_next     = count_reg;
        head_next      = '0;
        was_empty_next = 1'b0;
        overflow_next  = 1'b0;
        if (s_op == smpq_pkg::OP_INSERT) begin
            if (is_full) begin
                overflow_next = 1'b1;
                head_next     = cell_values[0];
            end else begin
                count_next = count_reg + smpq_pkg::cnt_t'(1);
                if (is_empty || (s_item_value > cell_values[0])) begin
                    head_next = s_item_value;
                end else begin
                    head_next = cell_values[0];
                end
            end
        end else begin
            if (is_empty) begin
                was_empty_next = 1'b1;
            end else begin
                head_next  = cell_values[0];
                count_next = count_reg - smpq_pkg::cnt_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_head_value_reg <= head_next;
            m_was_empty_reg  <= was_empty_next;
            m_overflow_reg   <= overflow_next;
            m_occupancy_reg  <= smpq_pkg::occ_t'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_head_value = m_head_value_reg;
    assign m_was_empty  = m_was_empty_reg;
    assign m_overflow   = m_overflow_reg;
    assign m_occupancy  = m_occupancy_reg;

endmodule

FILE: dv/sorted_max_priority_queue_top_tb.sv
// Self-checking testbench for the sorted max-priority queue with its own queue predictor.
module sorted_max_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 445;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic op;
        smpq_pkg::val_t value;
    } pq_request_t;

    typedef struct packed {
        smpq_pkg::val_t head;
        logic was_empty;
        logic overflow;
        smpq_pkg::occ_t occupancy;
    } pq_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = smpq_pkg::OP_INSERT;
    smpq_pkg::val_t s_item_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    smpq_pkg::val_t m_head_value;
    logic m_was_empty;
    logic m_overflow;
    smpq_pkg::occ_t m_occupancy;

    pq_request_t pending_requests[$];
    pq_result_t expected_results[$];

    smpq_pkg::val_t held_values [smpq_pkg::DEPTH];
    int held_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    sorted_max_priority_queue_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_item_value(s_item_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_head_value(m_head_value),
        .m_was_empty(m_was_empty),
        .m_overflow(m_overflow),
        .m_occupancy(m_occupancy)
    );

    always #2 aclk = ~aclk;

    function automatic pq_result_t apply_request(pq_request_t req);
        pq_result_t res;
        int pos;
        int i;
        res = '0;
        if (req.op == smpq_pkg::OP_INSERT) begin
            if (held_count >= smpq_pkg::DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_count && held_values[pos] >= req.value) pos++;
                for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
                held_values[pos] = req.value;
                held_count++;
            end
            if (held_count > 0) res.head = held_values[0];
        end else begin
            if (held_count == 0) begin
                res.was_empty = 1'b1;
            end else begin
                res.head = held_values[0];
                for (i = 1; i < held_count; i++) held_values[i-1] = held_values[i];
                held_count--;
            end
        end
        res.occupancy = smpq_pkg::occ_t'(held_count);
        return res;
    endfunction

    function automatic smpq_pkg::val_t pick_value();
        smpq_pkg::val_t v;
        case ($urandom_range(4))
            0, 1: v = smpq_pkg::val_t'($urandom);
            2: v = smpq_pkg::val_t'($urandom_range(16)) - 8;
            3: begin
                case ($urandom_range(3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = smpq_pkg::val_t'($urandom_range(1000)) * 1000 - 500000;
        endcase
        return v;
    endfunction

    task automatic push_request(logic op, smpq_pkg::val_t value);
        pending_requests.push_back('{op: op, value: value});
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        pq_request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_request('{op: s_op, value: s_item_value}));
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_op <= next_req.op;
                    s_item_value <= next_req.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pq_result_t want;
        pq_result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{head: m_head_value, was_empty: m_was_empty, overflow: m_overflow,
                        occupancy: m_occupancy};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Unexpected result transaction: ",
                                  "head %0d empty %0b ovf %0b occ %0d"},
                                 got.head, got.was_empty, got.overflow, got.occupancy);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"Mismatch: expected head %0d empty %0b ovf %0b occ %0d, ",
                                      "got head %0d empty %0b ovf %0b occ %0d"},
                                     want.head, want.was_empty, want.overflow, want.occupancy,
                                     got.head, got.was_empty, got.overflow, got.occupancy);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && (s_valid || pending_requests.size() != 0 || expected_results.size() != 0)
                && !(s_valid && s_ready) && !(m_valid && m_ready))
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_max_priority_queue_top regression: fail");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        int run_left;
        int insert_pct;
        logic op;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        push_request(smpq_pkg::OP_REMOVE, 32'sh5A5A_A5A5);
        push_request(smpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        push_request(smpq_pkg::OP_INSERT, 32'sh8000_0000);
        push_request(smpq_pkg::OP_INSERT, 0);
        push_request(smpq_pkg::OP_INSERT, -1);
        push_request(smpq_pkg::OP_INSERT, -1);
        push_request(smpq_pkg::OP_REMOVE, -1);
        push_request(smpq_pkg::OP_REMOVE, 0);
        for (n = 0; n < 13; n++)
            push_request(smpq_pkg::OP_INSERT, (n % 3 == 0) ? -1 : pick_value());
        push_request(smpq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        push_request(smpq_pkg::OP_REMOVE, 0);

        run_left = 0;
        insert_pct = 50;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 83; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 83; end
                default: begin send_idle_pct <= 37; recv_stall_pct <= 37; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 40);
                    case ($urandom_range(2))
                        0: insert_pct = 15;
                        1: insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                end
                run_left--;
                op = ($urandom_range(99) < insert_pct) ? smpq_pkg::OP_INSERT
                                                       : smpq_pkg::OP_REMOVE;
                push_request(op, pick_value());
            end
            wait_for_drain();
        end

        repeat (5) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sorted_max_priority_queue_top regression: pass");
        else
            $display("sorted_max_priority_queue_top regression: fail");
        $finish;
    end

endmodule
